FILE: sv/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = MAX_PATTERN * BYTE_W;
  localparam int LEN_W       = 4;
  localparam int FILL_W      = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] pat_bytes;
    logic [LEN_W-1:0]  pat_len;
    logic [WORD_W-1:0] rep_bytes;
    logic [LEN_W-1:0]  rep_len;
  } sfr_cfg_t;

  // One burst of output bytes for the back end; count 0 with last set is
  // the empty end marker.
  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [LEN_W-1:0]  count;
    logic              last;
  } sfr_cmd_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = (v > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : v;
    return r;
  endfunction

endpackage

FILE: sv/stream_find_replace.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// input     in         push / full            in_byte, in_byte_valid, end_of_string
// result    out        empty / pop            out_byte, out_byte_valid, last
// config    in/out     psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// The front end takes one item per cycle while its two-entry request queue
// has room; each item that yields results becomes one request in the queue.
// The back end loads one request at a time, only when idle, and gives out its
// 1..8 results in turn, each as the result slot is empty or being popped.
// Reset (rst, synchronous) clears the queue, the window fill and the config registers.
// A stalled result holds on the ports; the front keeps going until the queue fills.
module stream_find_replace import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_byte_valid,
  input  logic              end_of_string,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_byte_valid,
  output logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [WORD_W-1:0] pat_bytes;
  logic [LEN_W-1:0]  pat_len;
  logic [WORD_W-1:0] rep_bytes;
  logic [LEN_W-1:0]  rep_len;
  logic [1:0]        reg_idx;
  logic              reg_wr;
  logic              win_clear;
  sfr_cfg_t          cfg;

  logic              accept;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  sfr_cmd_t          q_wr;
  sfr_cmd_t          q_rd;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:3];
  assign reg_wr    = psel && penable && pwrite && pready;
  assign win_clear = reg_wr && (reg_idx == REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      pat_len   <= '0;
      rep_bytes <= '0;
      rep_len   <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_PATTERN_BYTES:      pat_bytes <= pwdata[WORD_W-1:0];
        REG_PATTERN_LENGTH:     pat_len   <= pwdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  rep_bytes <= pwdata[WORD_W-1:0];
        REG_REPLACEMENT_LENGTH: rep_len   <= pwdata[LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_BYTES:      prdata = DATA_W'(pat_bytes);
      REG_PATTERN_LENGTH:     prdata = DATA_W'(pat_len);
      REG_REPLACEMENT_BYTES:  prdata = DATA_W'(rep_bytes);
      REG_REPLACEMENT_LENGTH: prdata = DATA_W'(rep_len);
    endcase
  end

  assign cfg.pat_bytes = pat_bytes;
  assign cfg.pat_len   = clamp_len(pat_len);
  assign cfg.rep_bytes = rep_bytes;
  assign cfg.rep_len   = clamp_len(rep_len);

  assign full   = q_full;
  assign accept = push && !full;

  sfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .win_clear     (win_clear),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_byte_valid (in_byte_valid),
    .end_of_string (end_of_string),
    .cmd_push      (q_push),
    .cmd           (q_wr)
  );

  sfr_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .q_empty (q_empty)
  );

  sfr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (q_rd),
    .cmd_empty      (q_empty),
    .cmd_pop        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .last           (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("request popped from empty queue");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_byte_valid) |-> (last && out_byte == '0))
    else $error("empty marker without last or with nonzero byte");

  a_empty_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> empty)
    else $error("result present right after reset");

endmodule

FILE: sv/sfr_front.sv
`timescale 1ns / 1ps
module sfr_front import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sfr_cfg_t          cfg,
  input  logic              win_clear,
  input  logic              accept,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_byte_valid,
  input  logic              end_of_string,
  output logic              cmd_push,
  output sfr_cmd_t          cmd
);

  logic [BYTE_W-1:0] window [MAX_PATTERN];
  logic [BYTE_W-1:0] win_app [MAX_PATTERN];
  logic [BYTE_W-1:0] win_next [MAX_PATTERN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [LEN_W-1:0]  cnt_in;
  logic [LEN_W-1:0]  count;
  logic [WORD_W-1:0] win_flat;
  logic              full_win;
  logic              match;
  logic              use_rep;
  logic              slide;

  always_comb begin
    win_app = window;
    if (in_byte_valid) begin
      win_app[fill] = in_byte;
    end
    cnt_in = LEN_W'(fill) + LEN_W'(in_byte_valid);

    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < cfg.pat_len &&
          win_app[i] != cfg.pat_bytes[i*BYTE_W +: BYTE_W]) begin
        match = 1'b0;
      end
      win_flat[i*BYTE_W +: BYTE_W] = win_app[i];
    end

    full_win = in_byte_valid && (cfg.pat_len != '0) && (cnt_in == cfg.pat_len);
    use_rep  = 1'b0;
    slide    = 1'b0;

    priority if (cfg.pat_len == '0) begin
      count     = cnt_in;
      fill_next = '0;
    end else if (full_win && match) begin
      use_rep   = 1'b1;
      count     = cfg.rep_len;
      fill_next = '0;
    end else if (full_win) begin
      // oldest byte leaves; at end the rest of the window follows it
      slide     = !end_of_string;
      count     = end_of_string ? cnt_in : LEN_W'(1);
      fill_next = end_of_string ? '0 : FILL_W'(cnt_in - LEN_W'(1));
    end else begin
      count     = end_of_string ? cnt_in : '0;
      fill_next = end_of_string ? '0 : FILL_W'(cnt_in);
    end

    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (slide && i < MAX_PATTERN - 1) begin
        win_next[i] = win_app[i+1];
      end else begin
        win_next[i] = win_app[i];
      end
    end

    cmd.bytes = use_rep ? cfg.rep_bytes : win_flat;
    cmd.count = count;
    cmd.last  = end_of_string;
    cmd_push  = accept && (end_of_string || count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst || win_clear) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= win_next;
    end
  end

endmodule

FILE: sv/sfr_cmdq.sv
`timescale 1ns / 1ps
module sfr_cmdq import sfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  sfr_cmd_t wr_data,
  output logic     q_full,
  input  logic     rd_en,
  output sfr_cmd_t rd_data,
  output logic     q_empty
);

  sfr_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;

  assign q_full  = (used == 2'd2);
  assign q_empty = (used == 2'd0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: sv/sfr_back.sv
`timescale 1ns / 1ps
module sfr_back import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sfr_cmd_t          cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_byte_valid,
  output logic              last
);

  logic              busy;
  logic [WORD_W-1:0] cur_bytes;
  logic [LEN_W-1:0]  rem;
  logic              cur_last;
  logic              out_full;
  logic              slot_free;

  assign empty     = !out_full;
  assign slot_free = !out_full || pop;
  assign cmd_pop   = !busy && !cmd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      out_full <= 1'b0;
    end else begin
      // a new result fills the slot; a pop with nothing behind it drains it
      out_full <= (busy && slot_free) || (out_full && !pop);
      if (busy && slot_free) begin
        // rem of zero only occurs for the empty end marker
        out_byte       <= (rem != '0) ? cur_bytes[BYTE_W-1:0] : '0;
        out_byte_valid <= (rem != '0);
        last           <= cur_last && (rem <= LEN_W'(1));
        cur_bytes      <= {{BYTE_W{1'b0}}, cur_bytes[WORD_W-1:BYTE_W]};
        if (rem != '0) begin
          rem <= rem - LEN_W'(1);
        end
        if (rem <= LEN_W'(1)) begin
          busy <= 1'b0;
        end
      end else if (cmd_pop) begin
        busy      <= 1'b1;
        cur_bytes <= cmd.bytes;
        rem       <= cmd.count;
        cur_last  <= cmd.last;
      end
    end
  end

endmodule

FILE: tb/rewrite_checker.sv
`timescale 1ns / 1ps
module rewrite_checker import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_byte_valid,
  input  logic              end_of_string,
  input  logic              empty,
  input  logic              pop,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_byte_valid,
  input  logic              last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                chars_owed
);

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              ch_valid;
    logic              fin;
  } char_t;

  char_t             owed_q[$];
  logic [WORD_W-1:0] pat_word;
  logic [WORD_W-1:0] rep_word;
  logic [LEN_W-1:0]  pat_len;
  logic [LEN_W-1:0]  rep_len;
  logic [BYTE_W-1:0] window [MAX_PATTERN];
  int                fill;
  int                errs = 0;

  function automatic int clip(input logic [LEN_W-1:0] v);
    return (v > LEN_W'(MAX_PATTERN)) ? MAX_PATTERN : int'(v);
  endfunction

  task automatic owe(input logic [BYTE_W-1:0] c, input logic v);
    char_t e;
    e.ch = c;
    e.ch_valid = v;
    e.fin = 1'b0;
    owed_q.push_back(e);
  endtask

  // One accepted request: slide the window, emit what leaves it.
  task automatic rewrite_item(input logic [BYTE_W-1:0] b, input logic v, input logic eos);
    int    plen;
    int    rlen;
    int    start;
    int    i;
    logic  hit;
    char_t tail;
    start = owed_q.size();
    plen = clip(pat_len);
    rlen = clip(rep_len);
    if (v) begin
      if (plen == 0) begin
        owe(b, 1'b1);
      end else begin
        if (fill < MAX_PATTERN) begin
          window[fill] = b;
          fill++;
        end
        if (fill >= plen) begin
          hit = 1'b1;
          for (i = 0; i < plen; i++)
            if (window[i] != pat_word[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            for (i = 0; i < rlen; i++) owe(rep_word[8*i +: 8], 1'b1);
            fill = 0;
          end else begin
            owe(window[0], 1'b1);
            for (i = 0; i < MAX_PATTERN - 1; i++) window[i] = window[i+1];
            fill--;
          end
        end
      end
    end
    if (eos) begin
      for (i = 0; i < fill; i++) owe(window[i], 1'b1);
      fill = 0;
      // nothing came out of this end request: empty end marker
      if (owed_q.size() == start) owe('0, 1'b0);
      tail = owed_q.pop_back();
      tail.fin = 1'b1;
      owed_q.push_back(tail);
    end
  endtask

  task automatic check_char();
    char_t got;
    char_t exp_c;
    got = {out_byte, out_byte_valid, last};
    if (owed_q.size() == 0) begin
      $display("%0t unexpected result: byte %h valid %b last %b",
               $time, got.ch, got.ch_valid, got.fin);
      errs++;
    end else begin
      exp_c = owed_q.pop_front();
      if (got.ch !== exp_c.ch || got.ch_valid !== exp_c.ch_valid || got.fin !== exp_c.fin) begin
        $display("%0t result mismatch: expected byte %h valid %b last %b, actual byte %h valid %b last %b",
                 $time, exp_c.ch, exp_c.ch_valid, exp_c.fin, got.ch, got.ch_valid, got.fin);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      owed_q.delete();
      pat_word = '0;
      rep_word = '0;
      pat_len = '0;
      rep_len = '0;
      fill = 0;
    end else begin
      if (pop && !empty) check_char();
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:ADDR_W-2])
          REG_PATTERN_BYTES: pat_word = pwdata[WORD_W-1:0];
          REG_PATTERN_LENGTH: begin
            pat_len = pwdata[LEN_W-1:0];
            fill = 0;
          end
          REG_REPLACEMENT_BYTES: rep_word = pwdata[WORD_W-1:0];
          REG_REPLACEMENT_LENGTH: rep_len = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) rewrite_item(in_byte, in_byte_valid, end_of_string);
    end
    chars_owed = owed_q.size();
    mismatches = errs;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              in_byte_valid = 1'b0;
  logic              end_of_string = 1'b0;
  logic              pop = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic              full;
  logic              empty;
  logic [BYTE_W-1:0] out_byte;
  logic              out_byte_valid;
  logic              last;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int                mismatches;
  int                chars_owed;
  int                idle_cycles = 0;
  bit                calm = 1'b0;

  // what the sender knows of the current rules, to build matching text
  logic [WORD_W-1:0] pat_word = '0;
  int                pat_len = 0;
  logic [BYTE_W-1:0] alphabet [3];
  logic [BYTE_W-1:0] text[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stream_find_replace u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .in_byte(in_byte), .in_byte_valid(in_byte_valid), .end_of_string(end_of_string),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .out_byte_valid(out_byte_valid), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rewrite_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .in_byte(in_byte), .in_byte_valid(in_byte_valid), .end_of_string(end_of_string),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .out_byte_valid(out_byte_valid), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .chars_owed(chars_owed)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input logic [BYTE_W-1:0] b, input logic v, input logic eos);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_byte_valid <= v;
    end_of_string <= eos;
    do @(posedge clk); while (full);
  endtask

  // hold off the sender until every owed character has been popped
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rules(input logic [WORD_W-1:0] pat, input logic [LEN_W-1:0] plen,
                           input logic [WORD_W-1:0] rep, input logic [LEN_W-1:0] rlen);
    logic [DATA_W-1:0] up;
    settle();
    write_reg(REG_PATTERN_BYTES, pat);
    // junk above the length field must be dropped
    up = {$urandom, $urandom};
    if ($urandom_range(0, 1)) up = '0;
    write_reg(REG_PATTERN_LENGTH, {up[DATA_W-1:LEN_W], plen});
    write_reg(REG_REPLACEMENT_BYTES, rep);
    up = {$urandom, $urandom};
    if ($urandom_range(0, 1)) up = '0;
    write_reg(REG_REPLACEMENT_LENGTH, {up[DATA_W-1:LEN_W], rlen});
    pat_word = pat;
    pat_len = (plen > LEN_W'(MAX_PATTERN)) ? MAX_PATTERN : int'(plen);
  endtask

  // next chunk of text: whole pattern, a pattern prefix, or loose bytes
  task automatic refill();
    int r;
    int m;
    int i;
    r = $urandom_range(0, 99);
    if (r < 30 && pat_len > 0) begin
      for (i = 0; i < pat_len; i++) text.push_back(pat_word[8*i +: 8]);
    end else if (r < 50 && pat_len > 1) begin
      m = $urandom_range(1, pat_len - 1);
      for (i = 0; i < m; i++) text.push_back(pat_word[8*i +: 8]);
    end else if (r < 85) begin
      text.push_back(alphabet[$urandom_range(0, 2)]);
    end else begin
      text.push_back(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int kind);
    logic [WORD_W-1:0] pat;
    logic [WORD_W-1:0] rep;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    int                sent;
    int                r;
    int                k;
    for (k = 0; k < 3; k++) alphabet[k] = BYTE_W'($urandom_range(0, 255));
    if (kind == 5) begin
      alphabet[0] = 8'h00;
      alphabet[1] = 8'hFF;
    end
    for (k = 0; k < MAX_PATTERN; k++) pat[8*k +: 8] = alphabet[$urandom_range(0, 2)];
    rep = {$urandom, $urandom};
    case (kind)
      0: begin
        plen = '0;
        rlen = LEN_W'($urandom_range(0, 15));
      end
      1: begin
        plen = LEN_W'(MAX_PATTERN);
        rlen = LEN_W'(MAX_PATTERN);
      end
      2: begin
        plen = 4'd15;
        rlen = '0;
      end
      3: begin
        plen = 4'd1;
        rlen = LEN_W'($urandom_range(0, 15));
      end
      default: begin
        plen = LEN_W'($urandom_range(1, 5));
        rlen = LEN_W'($urandom_range(0, 15));
      end
    endcase
    set_rules(pat, plen, rep, rlen);
    calm = (kind == 4);
    text.delete();
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if (kind == 6 && sent == PHASE_ITEMS / 2) settle();
      if (text.size() == 0) refill();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
        if (r < 8) send(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        else send(text.pop_front(), 1'b1, r < 14);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : pop_side
    int burst;
    int g;
    forever begin
      burst = $urandom_range(1, 12);
      pop <= 1'b1;
      repeat (burst) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int p;
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset rules: pass-through, idle request, empty end
    send(8'h00, 1'b1, 1'b0);
    send(8'hFF, 1'b1, 1'b0);
    send(8'h5A, 1'b0, 1'b0);
    send(8'hA5, 1'b0, 1'b1);
    send(8'h3C, 1'b1, 1'b1);

    // "ab" -> "XYZ", replacement longer than match
    set_rules(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send(8'h61, 1'b1, 1'b0);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'h61, 1'b1, 1'b1);

    // deletion; final match deleted leaves the empty marker
    set_rules(64'h6261, 4'd2, 64'h0, 4'd0);
    send(8'h63, 1'b1, 1'b0);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b1);

    // oversized lengths saturate; full-width match gives eight results
    set_rules(64'h0807060504030201, 4'd15, 64'hF0E0D0C0B0A09080, 4'd15);
    for (i = 1; i <= MAX_PATTERN; i++) send(BYTE_W'(i), 1'b1, i == MAX_PATTERN);

    // zero bytes are ordinary characters
    set_rules(64'h0, 4'd2, 64'h0, 4'd1);
    send(8'h00, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b1);

    // writing the pattern length drops a held byte
    set_rules(64'h6261, 4'd2, 64'h58, 4'd1);
    send(8'h61, 1'b1, 1'b0);
    settle();
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    send(8'h77, 1'b0, 1'b1);

    for (p = 0; p < PHASES; p++) run_phase(p);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
